// ===== rtl/core/xmodem_crc_sender_defines.svh =====
// Assertion macros shared by the XMODEM-CRC sender RTL.
// Every macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef XMODEM_CRC_SENDER_DEFINES_SVH
`define XMODEM_CRC_SENDER_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define XCS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define XCS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define XCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/xcs_pkg.sv =====
// Package for the XMODEM-CRC sender: protocol symbols, input kind codes,
// packet layout constants, state types and the bytewise CRC-16 update.
// It depends on nothing else.
package xcs_pkg;

  // Payload bytes in one packet.
  localparam int PayloadLen = 128;

  // Protocol symbols.
  localparam logic [7:0] SymSoh  = 8'h01;
  localparam logic [7:0] SymEot  = 8'h04;
  localparam logic [7:0] SymAck  = 8'h06;
  localparam logic [7:0] SymNack = 8'h15;
  localparam logic [7:0] SymCan  = 8'h18;
  localparam logic [7:0] SymC    = 8'h43;

  localparam logic [15:0] CrcPoly = 16'h1021;

  // Byte positions within a packet.
  localparam logic [7:0] IdxSoh   = 8'd0;
  localparam logic [7:0] IdxSeq   = 8'd1;
  localparam logic [7:0] IdxNseq  = 8'd2;
  localparam logic [7:0] IdxData  = 8'd3;
  localparam logic [7:0] IdxCrcHi = 8'(3 + PayloadLen);
  localparam logic [7:0] IdxCrcLo = 8'(4 + PayloadLen);

  // Input beat kinds.
  localparam logic [1:0] KindFile  = 2'd0;
  localparam logic [1:0] KindReply = 2'd1;
  localparam logic [1:0] KindPull  = 2'd2;

  // Outcome codes.
  localparam logic [2:0] EndRunning   = 3'd0;
  localparam logic [2:0] EndCompleted = 3'd1;
  localparam logic [2:0] EndCancelled = 3'd2;
  localparam logic [2:0] EndRxEot     = 3'd3;
  localparam logic [2:0] EndUnknown   = 3'd4;

  // Configuration register index.
  localparam logic RegPadByte = 1'b0;

  typedef enum logic [2:0] {
    PH_LOADING,
    PH_SENDING,
    PH_AWAIT,
    PH_EOT_PENDING,
    PH_EOT_SENT,
    PH_DONE
  } phase_t;

  // Where the transmit byte of a beat comes from in the second stage.
  typedef enum logic [2:0] {
    SRC_NONE,
    SRC_CONST,
    SRC_RAM,
    SRC_CRC_HI,
    SRC_CRC_LO
  } src_t;

  // One CRC-16 step over a whole byte, most significant bit first.
  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/xmodem_crc_sender.sv =====
// XMODEM-CRC sender top level; uses xcs_pkg and xmodem_crc_sender_defines.svh.
//
// Input channel (in_*): each beat is a file byte (kind 0, in_tlast marks the
// final byte of the file), a reply byte from the receiver (kind 1) or a
// transmit slot pull (kind 2). Every accepted beat yields exactly one result
// beat on out_*, in order, carrying the byte to send (if any), whether a file
// byte was stored, the current packet number and the transfer outcome.
// The pad byte for a short final packet is set through the APB port.
// Timing: one beat is accepted per cycle unless the output stalls; each beat
// passes the first stage, then the output register. The first stage updates
// the control state and issues the payload memory read; the second stage
// picks the transmit byte from the memory's registered read data and folds
// it into the running CRC. If the receiver stalls, the output register holds
// its beat and one more beat may enter the first stage before in_tready falls.
// Reset clears all control state; sequence restarts at 1 and the pad byte at
// zero. The payload memory needs no clearing, as only written entries are read.
`include "xmodem_crc_sender_defines.svh"

module xmodem_crc_sender
  import xcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic [1:0]  in_tuser,   // [1:0] kind
  input  logic        in_tlast,   // last_of_file
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] tx_valid, [8:1] tx_byte, [9] data_accepted, [17:10] packet_number,
  // [20:18] outcome, [23:21] zero
  output logic [23:0] out_tdata,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Control state
  phase_t      phase_r, phase_nxt;
  logic [7:0]  fill_r, fill_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic        ready_r, ready_nxt;
  logic        final_r, final_nxt;
  logic [2:0]  end_r, end_nxt;
  logic [7:0]  pad_r;
  logic [15:0] crc_r, crc_nxt;

  // First stage
  logic        s1_valid_r;
  src_t        s1_src_r, s1_src_nxt;
  logic [7:0]  s1_byte_r, s1_byte_nxt;
  logic        s1_upd_r, s1_upd_nxt;
  logic        s1_clr_r, s1_clr_nxt;
  logic        s1_acc_r, s1_acc_nxt;
  logic [7:0]  s1_seq_r;
  logic [2:0]  s1_end_r;

  // Output register
  logic        out_valid_r;
  logic [23:0] out_data_r;

  // Payload memory
  logic [7:0]  mem [PayloadLen];
  logic [7:0]  ram_q_r;
  logic        wr_en, rd_en;
  logic [7:0]  pos;
  logic [7:0]  tx_byte;

  logic in_acc, out_adv, s1_adv;

  // Handshake: the output register frees when taken, the first stage when it moves on.
  assign out_adv   = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_adv;
  assign in_tready = !s1_valid_r || out_adv;
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign pos = idx_r - IdxData;

  // APB register access.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegPadByte) ? {24'h0, pad_r} : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_r <= 8'h00;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegPadByte) begin
      pad_r <= pwdata[7:0];
    end
  end

  // First stage: one protocol step per accepted beat.
  always_comb begin
    phase_nxt   = phase_r;
    fill_nxt    = fill_r;
    idx_nxt     = idx_r;
    seq_nxt     = seq_r;
    ready_nxt   = ready_r;
    final_nxt   = final_r;
    end_nxt     = end_r;
    s1_src_nxt  = SRC_NONE;
    s1_byte_nxt = 8'h00;
    s1_upd_nxt  = 1'b0;
    s1_clr_nxt  = 1'b0;
    s1_acc_nxt  = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    if (in_acc) begin
      unique case (in_tuser)
        KindFile: begin
          if (phase_r == PH_LOADING && fill_r < 8'(PayloadLen)) begin
            wr_en      = 1'b1;
            fill_nxt   = fill_r + 8'd1;
            s1_acc_nxt = 1'b1;
            if (in_tlast || fill_nxt >= 8'(PayloadLen)) begin
              final_nxt  = in_tlast;
              idx_nxt    = IdxSoh;
              s1_clr_nxt = 1'b1;
              phase_nxt  = PH_SENDING;
            end
          end
        end
        KindReply: begin
          priority case (phase_r)
            PH_LOADING, PH_SENDING: begin
              if (!ready_r && in_tdata == SymC) begin
                ready_nxt = 1'b1;
              end
            end
            PH_AWAIT: begin
              priority if (in_tdata == SymAck) begin
                seq_nxt = seq_r + 8'd1;
                if (final_r) begin
                  phase_nxt = PH_EOT_PENDING;
                end else begin
                  fill_nxt   = 8'd0;
                  idx_nxt    = IdxSoh;
                  s1_clr_nxt = 1'b1;
                  phase_nxt  = PH_LOADING;
                end
              end else if (in_tdata == SymNack) begin
                idx_nxt    = IdxSoh;
                s1_clr_nxt = 1'b1;
                phase_nxt  = PH_SENDING;
              end else if (in_tdata == SymCan) begin
                end_nxt   = EndCancelled;
                phase_nxt = PH_DONE;
              end else if (in_tdata == SymEot) begin
                end_nxt   = EndRxEot;
                phase_nxt = PH_DONE;
              end else begin
                end_nxt   = EndUnknown;
                phase_nxt = PH_DONE;
              end
            end
            PH_EOT_SENT: begin
              end_nxt   = EndCompleted;
              phase_nxt = PH_DONE;
            end
            default: begin
            end
          endcase
        end
        KindPull: begin
          if (phase_r == PH_SENDING && ready_r) begin
            priority if (idx_r == IdxSoh) begin
              s1_src_nxt  = SRC_CONST;
              s1_byte_nxt = SymSoh;
            end else if (idx_r == IdxSeq) begin
              s1_src_nxt  = SRC_CONST;
              s1_byte_nxt = seq_r;
            end else if (idx_r == IdxNseq) begin
              s1_src_nxt  = SRC_CONST;
              s1_byte_nxt = ~seq_r;
            end else if (idx_r < IdxCrcHi) begin
              s1_upd_nxt = 1'b1;
              if (pos < fill_r) begin
                s1_src_nxt = SRC_RAM;
                rd_en      = 1'b1;
              end else begin
                s1_src_nxt  = SRC_CONST;
                s1_byte_nxt = pad_r;
              end
            end else if (idx_r == IdxCrcHi) begin
              s1_src_nxt = SRC_CRC_HI;
            end else begin
              s1_src_nxt = SRC_CRC_LO;
            end
            if (idx_r >= IdxCrcLo) begin
              phase_nxt = PH_AWAIT;
            end else begin
              idx_nxt = idx_r + 8'd1;
            end
          end else if (phase_r == PH_EOT_PENDING) begin
            s1_src_nxt  = SRC_CONST;
            s1_byte_nxt = SymEot;
            phase_nxt   = PH_EOT_SENT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control state and first-stage registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_LOADING;
      fill_r     <= 8'd0;
      idx_r      <= IdxSoh;
      seq_r      <= 8'd1;
      ready_r    <= 1'b0;
      final_r    <= 1'b0;
      end_r      <= EndRunning;
      s1_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      fill_r  <= fill_nxt;
      idx_r   <= idx_nxt;
      seq_r   <= seq_nxt;
      ready_r <= ready_nxt;
      final_r <= final_nxt;
      end_r   <= end_nxt;
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_src_r  <= s1_src_nxt;
      s1_byte_r <= s1_byte_nxt;
      s1_upd_r  <= s1_upd_nxt;
      s1_clr_r  <= s1_clr_nxt;
      s1_acc_r  <= s1_acc_nxt;
      s1_seq_r  <= seq_nxt;
      s1_end_r  <= end_nxt;
    end
  end

  // Payload memory. Reads only happen on accepted beats, so the read data
  // holds while the first stage waits. A byte is always written at least
  // three beats before the first payload read of its packet.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill_r[6:0]] <= in_tdata;
    end
    if (rd_en) begin
      ram_q_r <= mem[pos[6:0]];
    end
  end

  // Second stage: transmit byte selection and running CRC.
  always_comb begin
    unique case (s1_src_r)
      SRC_CONST:  tx_byte = s1_byte_r;
      SRC_RAM:    tx_byte = ram_q_r;
      SRC_CRC_HI: tx_byte = crc_r[15:8];
      SRC_CRC_LO: tx_byte = crc_r[7:0];
      default:    tx_byte = 8'h00;
    endcase
    priority if (s1_clr_r) begin
      crc_nxt = 16'h0000;
    end else if (s1_upd_r) begin
      crc_nxt = crc_add(crc_r, tx_byte);
    end else begin
      crc_nxt = crc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= 16'h0000;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        crc_r       <= crc_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= {3'b000, s1_end_r, s1_seq_r, s1_acc_r, tx_byte,
                     (s1_src_r != SRC_NONE)};
    end
  end

  // Checks on the block's own logic.
  `XCS_ASSERT_SAME(a_rd_only_sending, rd_en, phase_r == PH_SENDING && ready_r,
                   "payload read outside the sending phase")
  `XCS_ASSERT_ALWAYS(a_fill_bound, fill_r <= 8'(PayloadLen),
                     "fill count beyond the packet length")
  `XCS_ASSERT_ALWAYS(a_idx_bound, idx_r <= IdxCrcLo,
                     "send index beyond the last CRC byte")
  `XCS_ASSERT_SAME(a_end_done, end_r != EndRunning, phase_r == PH_DONE,
                   "outcome set while the transfer still runs")
  `XCS_ASSERT_NEXT(a_s1_hold, s1_valid_r && !out_adv, s1_valid_r,
                   "first stage beat lost while the output stalls")

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the XMODEM-CRC sender: streams file, reply and pull beats,
// predicts every result beat and checks it. Depends on xcs_pkg and xmodem_crc_sender.
module tb_top;
  import xcs_pkg::*;

  localparam logic [1:0]  KindUnused    = 2'd3;
  localparam logic [2:0]  PadAddr       = {RegPadByte, 2'b00};
  localparam int          PacketBeats   = PayloadLen + 5;
  localparam int          RandomPartEnd = 500;
  localparam int          LongHold      = 120;
  localparam int          DrainPause    = 6;
  localparam int          WatchdogLimit = 2000;
  localparam int          MaxReported   = 40;

  // Receiver readiness styles, a new one drawn at random whenever rx_tick wraps to zero.
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_MOSTLY,
    RX_EVERY_THIRD,
    RX_COIN
  } rx_style_t;

  // Result beat as laid out on out_tdata, lowest field last.
  typedef struct packed {
    logic [2:0] spare;
    logic [2:0] outcome;
    logic [7:0] packet_number;
    logic       data_accepted;
    logic [7:0] tx_byte;
    logic       tx_valid;
  } result_beat_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata  = '0;   // [7:0] byte_value
  logic [1:0]  in_tuser  = '0;   // [1:0] kind
  logic        in_tlast  = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;        // [0] tx_valid, [8:1] tx_byte, [9] data_accepted,
                                 // [17:10] packet_number, [20:18] outcome, [23:21] zero
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  // Sender-side mirror of the block's state.
  phase_t      xm_phase = PH_LOADING;
  logic [7:0]  xm_store [PayloadLen];
  logic [7:0]  xm_fill  = '0;
  logic [7:0]  xm_index = '0;
  logic [7:0]  xm_seq   = 8'd1;
  logic [15:0] xm_crc   = '0;
  logic        xm_ready = 1'b0;
  logic        xm_final = 1'b0;
  logic [2:0]  xm_end   = EndRunning;
  logic [7:0]  xm_pad   = '0;

  result_beat_t expected_out_beats [$];
  int unsigned  mismatch_count = 0;
  int unsigned  beats_accepted = 0;
  int unsigned  burst_left     = 0;

  // Receiver stall control: a toggle of rx_hold_req asks for one long hold-off.
  logic         rx_hold_req  = 1'b0;
  logic         rx_hold_seen = 1'b0;
  int unsigned  rx_hold_left = 0;
  int unsigned  rx_tick      = 0;
  rx_style_t    rx_mode      = RX_ALWAYS;

  xmodem_crc_sender uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #10 clk = ~clk;

  // CRC-16 over one byte, bit by bit with the feedback taken from the top CRC bit XOR the data bit.
  function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ data[i];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  // Advances the mirrored sender by one accepted beat and returns its result beat.
  function automatic result_beat_t predict_sender_beat(input logic [1:0] kind,
                                                       input logic [7:0] value,
                                                       input logic is_last);
    result_beat_t beat;
    logic [7:0]   pos;
    beat = '0;
    case (kind)
      KindFile: begin
        if (xm_phase == PH_LOADING && xm_fill < 8'(PayloadLen)) begin
          xm_store[xm_fill[6:0]] = value;
          xm_fill = xm_fill + 8'd1;
          beat.data_accepted = 1'b1;
          if (is_last || xm_fill == 8'(PayloadLen)) begin
            xm_final = is_last;
            xm_index = '0;
            xm_crc   = '0;
            xm_phase = PH_SENDING;
          end
        end
      end
      KindReply: begin
        if (xm_phase == PH_LOADING || xm_phase == PH_SENDING) begin
          if (!xm_ready && value == SymC) begin
            xm_ready = 1'b1;
          end
        end else if (xm_phase == PH_AWAIT) begin
          if (value == SymAck) begin
            xm_seq = xm_seq + 8'd1;
            if (xm_final) begin
              xm_phase = PH_EOT_PENDING;
            end else begin
              xm_fill  = '0;
              xm_index = '0;
              xm_crc   = '0;
              xm_phase = PH_LOADING;
            end
          end else if (value == SymNack) begin
            xm_index = '0;
            xm_crc   = '0;
            xm_phase = PH_SENDING;
          end else begin
            xm_end = (value == SymCan) ? EndCancelled :
                     (value == SymEot) ? EndRxEot : EndUnknown;
            xm_phase = PH_DONE;
          end
        end else if (xm_phase == PH_EOT_SENT) begin
          xm_end   = EndCompleted;
          xm_phase = PH_DONE;
        end
      end
      KindPull: begin
        if (xm_phase == PH_SENDING && xm_ready) begin
          beat.tx_valid = 1'b1;
          if (xm_index == IdxSoh) begin
            beat.tx_byte = SymSoh;
          end else if (xm_index == IdxSeq) begin
            beat.tx_byte = xm_seq;
          end else if (xm_index == IdxNseq) begin
            beat.tx_byte = ~xm_seq;
          end else if (xm_index < IdxCrcHi) begin
            // Payload: stored bytes first, then padding up to the full length.
            pos = xm_index - IdxData;
            beat.tx_byte = (pos < xm_fill) ? xm_store[pos[6:0]] : xm_pad;
            xm_crc = crc16_fold(xm_crc, beat.tx_byte);
          end else if (xm_index == IdxCrcHi) begin
            beat.tx_byte = xm_crc[15:8];
          end else begin
            beat.tx_byte = xm_crc[7:0];
          end
          if (xm_index >= IdxCrcLo) begin
            xm_phase = PH_AWAIT;
          end else begin
            xm_index = xm_index + 8'd1;
          end
        end else if (xm_phase == PH_EOT_PENDING) begin
          beat.tx_valid = 1'b1;
          beat.tx_byte  = SymEot;
          xm_phase      = PH_EOT_SENT;
        end
      end
      default: begin
      end
    endcase
    beat.packet_number = xm_seq;
    beat.outcome       = xm_end;
    return beat;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < MaxReported) begin
      $display("%0t mismatch: %s", $time, what);
    end
    mismatch_count++;
  endtask

  // Predict on every accepted input beat, then check any accepted result beat.
  always @(posedge clk) begin : result_check
    result_beat_t got;
    result_beat_t want;
    if (rst_n && in_tvalid && in_tready) begin
      expected_out_beats.push_back(predict_sender_beat(in_tuser, in_tdata, in_tlast));
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = result_beat_t'(out_tdata);
      if (expected_out_beats.size() == 0) begin
        report_mismatch($sformatf("result beat %06h with no input beat outstanding", out_tdata));
      end else begin
        want = expected_out_beats.pop_front();
        if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
            got.data_accepted !== want.data_accepted ||
            got.packet_number !== want.packet_number ||
            got.outcome !== want.outcome || got.spare !== want.spare) begin
          report_mismatch($sformatf(
            "valid/byte/acc/pkt/end/spare want %0b/%02h/%0b/%0d/%0d/%0d got %0b/%02h/%0b/%0d/%0d/%0d",
            want.tx_valid, want.tx_byte, want.data_accepted, want.packet_number,
            want.outcome, want.spare, got.tx_valid, got.tx_byte, got.data_accepted,
            got.packet_number, got.outcome, got.spare));
        end
      end
    end
  end

  // Receiver: a long hold-off on request, otherwise a readiness style of its own.
  always @(posedge clk) begin : receiver
    if (rx_hold_req != rx_hold_seen) begin
      rx_hold_seen <= rx_hold_req;
      rx_hold_left <= LongHold;
      out_tready   <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_tready   <= 1'b0;
    end else begin
      if (rx_tick == 0) begin
        rx_mode <= rx_style_t'($urandom_range(0, 3));
      end
      rx_tick <= (rx_tick == 63) ? 0 : rx_tick + 1;
      case (rx_mode)
        RX_ALWAYS:      out_tready <= 1'b1;
        RX_MOSTLY:      out_tready <= ($urandom_range(0, 3) != 0);
        RX_EVERY_THIRD: out_tready <= (rx_tick % 3 == 0);
        default:        out_tready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // Watchdog: ends the run after a long stretch with no beat moving on any port.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || psel) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[xmodem_crc_sender] ERROR");
    $finish;
  end

  // Offers one input beat, in bursts with random gaps, and waits until it is taken.
  task automatic push_beat(input logic [1:0] kind, input logic [7:0] value, input logic is_last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= value;
    in_tlast  <= is_last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_accepted++;
  endtask

  // A beat that should leave the transfer alone in the current phase.
  task automatic push_noise(input bit replies_ok, input bit files_ok, input bit c_ok);
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0: push_beat(KindPull, v, 1'($urandom_range(0, 1)));
      1: push_beat(KindUnused, v, 1'($urandom_range(0, 1)));
      2: begin
        if (replies_ok) begin
          if (!c_ok && v == SymC) begin
            v = ~v;
          end
          push_beat(KindReply, v, 1'($urandom_range(0, 1)));
        end else begin
          push_beat(KindPull, v, 1'($urandom_range(0, 1)));
        end
      end
      default: begin
        if (files_ok) begin
          push_beat(KindFile, v, 1'($urandom_range(0, 1)));
        end else begin
          push_beat(KindUnused, v, 1'($urandom_range(0, 1)));
        end
      end
    endcase
  endtask

  task automatic answer(input logic [7:0] reply);
    push_beat(KindReply, reply, 1'($urandom_range(0, 1)));
  endtask

  // Loads n random file bytes, with harmless beats mixed in.
  task automatic load_payload(input int n, input bit mark_last, input int noise_pct,
                              input bit c_ok);
    for (int i = 0; i < n; i++) begin
      while ($urandom_range(0, 99) < noise_pct) push_noise(1'b1, 1'b0, c_ok);
      push_beat(KindFile, 8'($urandom_range(0, 255)), mark_last && (i == n - 1));
    end
  endtask

  // Pulls one whole packet out; noise beats may also follow the last pull.
  task automatic pull_packet(input int noise_pct);
    for (int i = 0; i < PacketBeats; i++) begin
      while ($urandom_range(0, 99) < noise_pct) push_noise(1'b1, 1'b1, 1'b1);
      push_beat(KindPull, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
    if (noise_pct > 0) begin
      repeat ($urandom_range(0, 2)) push_noise(1'b0, 1'b1, 1'b1);
    end
  endtask

  // Stops offering and waits until every predicted result beat has come out.
  task automatic wait_until_drained();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_out_beats.size() != 0) @(posedge clk);
    repeat (DrainPause) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == PadAddr) begin
      xm_pad = data[7:0];
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Writes the pad byte and reads it back; the block must be idle.
  task automatic set_pad_byte(input logic [7:0] pad);
    logic [31:0] readback;
    apb_write(PadAddr, {24'h0, pad});
    apb_read(PadAddr, readback);
    if (readback[7:0] !== pad) begin
      report_mismatch($sformatf("pad byte reads %02h after writing %02h", readback[7:0], pad));
    end
  endtask

  // Reset value of the pad register, then both extremes and the usual fill.
  task automatic test_pad_register();
    logic [31:0] readback;
    apb_read(PadAddr, readback);
    if (readback[7:0] !== 8'h00) begin
      report_mismatch($sformatf("pad byte reads %02h after reset", readback[7:0]));
    end
    set_pad_byte(8'hFF);
    set_pad_byte(8'h00);
    set_pad_byte(8'h1A);
  endtask

  // Before 'C': pulls and unused kinds are idle, other reply bytes are ignored, file bytes are stored.
  task automatic test_before_receiver_ready();
    push_beat(KindPull, 8'hFF, 1'b1);
    push_beat(KindUnused, 8'hFF, 1'b1);
    answer(8'h00);
    answer(8'hFF);
    answer(SymAck);
    answer(SymNack);
    answer(SymCan);
    answer(SymEot);
    push_beat(KindFile, 8'h00, 1'b0);
    push_beat(KindFile, 8'hFF, 1'b0);
    push_beat(KindFile, 8'h55, 1'b0);
    push_beat(KindFile, 8'hAA, 1'b0);
    push_beat(KindPull, 8'h00, 1'b0);
  endtask

  // Fill the first packet, show that a full buffer refuses bytes and that pulls
  // stay idle until 'C' arrives while sending; replies mid-packet are ignored.
  task automatic test_first_packet();
    load_payload(PayloadLen - 4, 1'b0, 15, 1'b0);
    push_beat(KindFile, 8'h5A, 1'b1);
    push_beat(KindFile, 8'hA5, 1'b0);
    push_beat(KindPull, 8'h00, 1'b0);
    push_beat(KindPull, 8'hFF, 1'b1);
    answer(SymC);
    pull_packet(15);
    answer(SymNack);
  endtask

  // Resend the packet while the receiver holds off long enough to back up the input.
  task automatic test_resend_under_backpressure();
    rx_hold_req <= ~rx_hold_req;
    pull_packet(0);
    answer(SymAck);
  endtask

  // Full packets with random content, occasional resends and pad changes.
  task automatic test_random_packets();
    bit resend;
    while (beats_accepted < RandomPartEnd) begin
      load_payload(PayloadLen, 1'b0, 10, 1'b1);
      do begin
        pull_packet(10);
        resend = ($urandom_range(0, 4) == 0);
        if (resend && $urandom_range(0, 1) == 1) begin
          wait_until_drained();
          set_pad_byte(8'($urandom_range(0, 255)));
        end
        answer(resend ? SymNack : SymAck);
      end while (resend);
    end
  endtask

  // The final packet, usually short, resent under several pad settings.
  task automatic test_final_packet();
    int len;
    case ($urandom_range(0, 3))
      0:       len = 1;
      1:       len = PayloadLen;
      2:       len = PayloadLen - 1;
      default: len = $urandom_range(2, PayloadLen - 2);
    endcase
    load_payload(len, 1'b1, 10, 1'b1);
    pull_packet(10);
    answer(SymNack);
    wait_until_drained();
    set_pad_byte(8'hFF);
    pull_packet(0);
    answer(SymNack);
    wait_until_drained();
    set_pad_byte(8'h00);
    pull_packet(10);
  endtask

  // One way of ending the transfer, chosen at random; completion is the most common.
  task automatic test_transfer_end();
    logic [7:0] other;
    case ($urandom_range(0, 6))
      0, 1, 2: begin
        answer(SymAck);
        // EOT is pending: replies and file bytes change nothing.
        answer(8'($urandom_range(0, 255)));
        push_beat(KindFile, 8'($urandom_range(0, 255)), 1'b1);
        push_beat(KindPull, 8'h00, 1'b0);
        push_beat(KindPull, 8'h00, 1'b0);
        answer(8'($urandom_range(0, 255)));
      end
      3: answer(SymCan);
      4: answer(SymEot);
      5: begin
        do begin
          other = 8'($urandom_range(0, 255));
        end while (other == SymAck || other == SymNack || other == SymCan ||
                   other == SymEot || other == SymC);
        answer(other);
      end
      default: answer(SymC);
    endcase
  endtask

  // Once finished, every beat is idle and the outcome holds.
  task automatic test_after_done();
    repeat (12) begin
      push_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_pad_register();
    test_before_receiver_ready();
    test_first_packet();
    test_resend_under_backpressure();
    test_random_packets();
    test_final_packet();
    test_transfer_end();
    test_after_done();
    wait_until_drained();
    if (mismatch_count == 0) begin
      $display("[xmodem_crc_sender] OK");
    end else begin
      $display("[xmodem_crc_sender] ERROR");
    end
    $finish;
  end

endmodule
